// ===== rtl/cbsc_pkg.sv =====
// Shared constants for the convex brush segment clipper.
package cbsc_pkg;
   localparam int NORMAL_BITS = 16;
   localparam int NORMAL_SHIFT = 14;
   localparam int EPS_BITS = 8;
   localparam int KIND_BITS = 2;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [KIND_BITS-1:0] KIND_SPHERE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_BOX = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRACE_START = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRACE_END = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_MIN = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_MAX = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OBJECT_KIND = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPHERE_RADIUS = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLIP_EPSILON = 3'd6;

   localparam logic [EPS_BITS-1:0] EPS_RESET = 8'd8;

   typedef struct packed {
      logic push;
      logic full;
   } queue_wr_type;
endpackage

// ===== rtl/cbsc_front.sv =====
// Front end: accepts planes and forms start and end plane distances.
module cbsc_front import cbsc_pkg::*; #(
   parameter int CW = 20,
   parameter int LB = 16,
   parameter int SW = CW + 21
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic                        req_new_trace,
   input  logic signed [NORMAL_BITS-1:0] req_normal_x,
   input  logic signed [NORMAL_BITS-1:0] req_normal_y,
   input  logic signed [NORMAL_BITS-1:0] req_normal_z,
   input  logic signed [CW-1:0]        req_plane_dist,
   input  logic [LB-1:0]               req_leaf_index,
   input  logic                        req_last_side,
   input  logic [3*CW-1:0]             trace_start,
   input  logic [3*CW-1:0]             trace_end,
   input  logic [3*CW-1:0]             box_min,
   input  logic [3*CW-1:0]             box_max,
   input  logic [KIND_BITS-1:0]        object_kind,
   input  logic [CW-2:0]               sphere_radius,
   output queue_wr_type                qw,
   input  logic                        q_full,
   output logic [2*SW+3*NORMAL_BITS+LB+1:0] q_data
);
   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_MUL = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic signed [SW-1:0] acc_s_ff, acc_s_in, acc_e_ff, acc_e_in;
   logic signed [NORMAL_BITS-1:0] nx_ff, ny_ff, nz_ff, n_sel;
   logic [LB-1:0] leaf_ff;
   logic new_ff, last_ff;
   logic signed [CW-1:0] s_c, e_c, off_c;
   logic signed [CW:0] sum_s, sum_e;
   logic signed [CW+16:0] prod_s, prod_e;
   logic signed [SW-1:0] dterm, rterm;
   logic accept;

   assign accept = req_push && !req_full;
   assign req_full = (state_ff != F_IDLE);

   always_comb begin
      case (axis_ff)
         2'd0: n_sel = nx_ff;
         2'd1: n_sel = ny_ff;
         default: n_sel = nz_ff;
      endcase
      s_c = trace_start[axis_ff*CW +: CW];
      e_c = trace_end[axis_ff*CW +: CW];
      if (object_kind == KIND_BOX) begin
         off_c = n_sel[NORMAL_BITS-1] ? box_max[axis_ff*CW +: CW] : box_min[axis_ff*CW +: CW];
      end else begin
         off_c = '0;
      end
      sum_s = (CW+1)'(s_c) + (CW+1)'(off_c);
      sum_e = (CW+1)'(e_c) + (CW+1)'(off_c);
      prod_s = (CW+17)'(n_sel) * (CW+17)'(sum_s);
      prod_e = (CW+17)'(n_sel) * (CW+17)'(sum_e);
      dterm = SW'(req_plane_dist) <<< NORMAL_SHIFT;
      rterm = (object_kind == KIND_SPHERE) ?
              (SW'($signed({1'b0, sphere_radius})) <<< NORMAL_SHIFT) : '0;
   end

   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff;
      acc_s_in = acc_s_ff;
      acc_e_in = acc_e_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_MUL;
               axis_in = '0;
               acc_s_in = -dterm - rterm;
               acc_e_in = -dterm - rterm;
            end
         end
         F_MUL: begin
            acc_s_in = acc_s_ff + SW'(prod_s);
            acc_e_in = acc_e_ff + SW'(prod_e);
            axis_in = axis_ff + 2'd1;
            if (axis_ff == 2'd2) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff <= axis_in;
      acc_s_ff <= acc_s_in;
      acc_e_ff <= acc_e_in;
      if (accept) begin
         nx_ff <= req_normal_x;
         ny_ff <= req_normal_y;
         nz_ff <= req_normal_z;
         leaf_ff <= req_leaf_index;
         new_ff <= req_new_trace;
         last_ff <= req_last_side;
      end
   end

   assign qw.push = (state_ff == F_PUSH) && !q_full;
   assign qw.full = q_full;
   assign q_data = {acc_s_ff, acc_e_ff, nx_ff, ny_ff, nz_ff, leaf_ff, new_ff, last_ff};
endmodule

// ===== rtl/cbsc_queue.sv =====
// Two-entry queue between the front end and the back end.
module cbsc_queue import cbsc_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_wr_type     qw,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (qw.push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop && !empty) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(qw.push) - 2'(pop && !empty);
      end
   end

   always_ff @(posedge clock) begin
      if (qw.push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end
endmodule

// ===== rtl/cbsc_back.sv =====
// Back end: fraction divider, brush clipping state and nearest-hit result.
module cbsc_back import cbsc_pkg::*; #(
   parameter int CW = 20,
   parameter int FB = 16,
   parameter int LB = 16,
   parameter int SW = CW + 21
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  logic [2*SW+3*NORMAL_BITS+LB+1:0] q_data,
   input  logic [EPS_BITS-1:0]  clip_epsilon,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [FB:0]          rsp_hit_fraction,
   output logic signed [NORMAL_BITS-1:0] rsp_hit_normal_x,
   output logic signed [NORMAL_BITS-1:0] rsp_hit_normal_y,
   output logic signed [NORMAL_BITS-1:0] rsp_hit_normal_z,
   output logic [LB-1:0]        rsp_hit_leaf,
   output logic                 rsp_start_outside,
   output logic                 rsp_all_solid,
   output logic                 rsp_hit_updated
);
   localparam int DVW = SW + 2;
   localparam int CNTW = $clog2(FB);
   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_EVAL = 3'd1;
   localparam logic [2:0] B_DIV = 3'd2;
   localparam logic [2:0] B_UPD = 3'd3;
   localparam logic [2:0] B_FIN = 3'd4;
   localparam logic [FB:0] ONE_U = (FB+1)'(1) << FB;
   localparam logic signed [FB+1:0] ONE_S = (FB+2)'(1) << FB;

   logic [2:0] state_ff;
   logic signed [SW-1:0] sd_ff, ed_ff, q_sd, q_ed;
   logic signed [NORMAL_BITS-1:0] n_ff [3];
   logic signed [NORMAL_BITS-1:0] q_n [3];
   logic [LB-1:0] leaf_ff, q_leaf;
   logic last_ff, q_new, q_last;

   logic [FB:0] best_ff, best_in;
   logic signed [NORMAL_BITS-1:0] best_n_ff [3];
   logic [LB-1:0] best_leaf_ff;
   logic start_out_ff, start_out_in, solid_ff, solid_in, upd_in;
   logic signed [FB+1:0] enter_ff, exit_ff;
   logic starts_ff, ends_ff, rejected_ff;
   logic signed [NORMAL_BITS-1:0] cand_ff [3];

   logic [DVW-1:0] rem_ff, den_ff;
   logic [FB-1:0] quo_ff;
   logic [CNTW-1:0] cnt_ff;
   logic neg_ff, entering_ff, sat_ff, zero_ff;

   logic signed [DVW-1:0] num_c, den_c, eps_c;
   logic [DVW-1:0] un_c, ud_c;
   logic [DVW:0] rem2_c;
   logic rem_ge_c;
   logic [FB:0] mag_c;
   logic signed [FB+1:0] f_c;
   logic sp_c, ep_c, take_c;

   logic out_valid_ff;
   logic [FB:0] o_frac_ff;
   logic signed [NORMAL_BITS-1:0] o_n_ff [3];
   logic [LB-1:0] o_leaf_ff;
   logic o_so_ff, o_solid_ff, o_upd_ff;
   logic fin_go;

   assign {q_sd, q_ed, q_n[0], q_n[1], q_n[2], q_leaf, q_new, q_last} = q_data;
   assign q_pop = (state_ff == B_IDLE) && !q_empty;

   always_comb begin
      sp_c = (sd_ff > 0);
      ep_c = (ed_ff > 0);
      eps_c = DVW'($signed({1'b0, clip_epsilon})) <<< NORMAL_SHIFT;
      num_c = (sd_ff > ed_ff) ? (DVW'(sd_ff) - eps_c) : (DVW'(sd_ff) + eps_c);
      den_c = DVW'(sd_ff) - DVW'(ed_ff);
      un_c = num_c[DVW-1] ? DVW'(-num_c) : DVW'(num_c);
      ud_c = den_c[DVW-1] ? DVW'(-den_c) : DVW'(den_c);
      rem2_c = {rem_ff, 1'b0};
      rem_ge_c = (rem2_c >= {1'b0, den_ff});
      mag_c = sat_ff ? ONE_U : (zero_ff ? '0 : {1'b0, quo_ff});
      f_c = neg_ff ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
   end

   always_comb begin
      best_in = best_ff;
      start_out_in = start_out_ff;
      solid_in = solid_ff;
      upd_in = 1'b0;
      take_c = 1'b0;
      if (!rejected_ff) begin
         if (!starts_ff) begin
            start_out_in = 1'b0;
            if (!ends_ff) begin
               solid_in = 1'b1;
            end
         end else if (enter_ff < exit_ff && enter_ff > -ONE_S &&
                      enter_ff < $signed({1'b0, best_ff})) begin
            best_in = enter_ff[FB+1] ? '0 : enter_ff[FB:0];
            upd_in = 1'b1;
            take_c = 1'b1;
         end
      end
   end

   assign fin_go = (state_ff == B_FIN) && last_ff && (!out_valid_ff || rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         out_valid_ff <= 1'b0;
         best_ff <= ONE_U;
         best_leaf_ff <= '0;
         start_out_ff <= 1'b1;
         solid_ff <= 1'b0;
         enter_ff <= -ONE_S;
         exit_ff <= ONE_S;
         starts_ff <= 1'b0;
         ends_ff <= 1'b0;
         rejected_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            best_n_ff[i] <= '0;
            cand_ff[i] <= '0;
         end
      end else begin
         if (fin_go) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  if (q_new) begin
                     best_ff <= ONE_U;
                     best_leaf_ff <= '0;
                     start_out_ff <= 1'b1;
                     solid_ff <= 1'b0;
                     enter_ff <= -ONE_S;
                     exit_ff <= ONE_S;
                     starts_ff <= 1'b0;
                     ends_ff <= 1'b0;
                     rejected_ff <= 1'b0;
                     for (int i = 0; i < 3; i++) begin
                        best_n_ff[i] <= '0;
                        cand_ff[i] <= '0;
                     end
                  end
                  state_ff <= B_EVAL;
               end
            end
            B_EVAL: begin
               if (!rejected_ff && (sp_c ^ ep_c)) begin
                  state_ff <= (ud_c == '0 || un_c >= ud_c) ? B_UPD : B_DIV;
               end else begin
                  state_ff <= B_FIN;
               end
               if (!rejected_ff) begin
                  if (sp_c) begin
                     starts_ff <= 1'b1;
                  end
                  if (ep_c) begin
                     ends_ff <= 1'b1;
                  end
                  if (sp_c && ep_c) begin
                     rejected_ff <= 1'b1;
                  end
               end
            end
            B_DIV: begin
               if (cnt_ff == CNTW'(FB - 1)) begin
                  state_ff <= B_UPD;
               end
            end
            B_UPD: begin
               if (entering_ff && f_c > enter_ff) begin
                  enter_ff <= f_c;
                  for (int i = 0; i < 3; i++) begin
                     cand_ff[i] <= n_ff[i];
                  end
               end
               if (!entering_ff && f_c < exit_ff) begin
                  exit_ff <= f_c;
               end
               state_ff <= B_FIN;
            end
            B_FIN: begin
               if (!last_ff) begin
                  state_ff <= B_IDLE;
               end else if (fin_go) begin
                  best_ff <= best_in;
                  start_out_ff <= start_out_in;
                  solid_ff <= solid_in;
                  if (take_c) begin
                     best_leaf_ff <= leaf_ff;
                     for (int i = 0; i < 3; i++) begin
                        best_n_ff[i] <= cand_ff[i];
                     end
                  end
                  enter_ff <= -ONE_S;
                  exit_ff <= ONE_S;
                  starts_ff <= 1'b0;
                  ends_ff <= 1'b0;
                  rejected_ff <= 1'b0;
                  for (int i = 0; i < 3; i++) begin
                     cand_ff[i] <= '0;
                  end
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         sd_ff <= q_sd;
         ed_ff <= q_ed;
         leaf_ff <= q_leaf;
         last_ff <= q_last;
         for (int i = 0; i < 3; i++) begin
            n_ff[i] <= q_n[i];
         end
      end
      if (state_ff == B_EVAL) begin
         entering_ff <= (sd_ff > ed_ff);
         neg_ff <= num_c[DVW-1] ^ den_c[DVW-1];
         sat_ff <= (ud_c != '0) && (un_c >= ud_c);
         zero_ff <= (ud_c == '0);
         rem_ff <= un_c;
         den_ff <= ud_c;
         quo_ff <= '0;
         cnt_ff <= '0;
      end else if (state_ff == B_DIV) begin
         rem_ff <= rem_ge_c ? DVW'(rem2_c - {1'b0, den_ff}) : DVW'(rem2_c);
         quo_ff <= {quo_ff[FB-2:0], rem_ge_c};
         cnt_ff <= cnt_ff + CNTW'(1);
      end
      if (fin_go) begin
         o_frac_ff <= best_in;
         o_leaf_ff <= take_c ? leaf_ff : best_leaf_ff;
         for (int i = 0; i < 3; i++) begin
            o_n_ff[i] <= take_c ? cand_ff[i] : best_n_ff[i];
         end
         o_so_ff <= start_out_in;
         o_solid_ff <= solid_in;
         o_upd_ff <= upd_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_hit_fraction = o_frac_ff;
   assign rsp_hit_normal_x = o_n_ff[0];
   assign rsp_hit_normal_y = o_n_ff[1];
   assign rsp_hit_normal_z = o_n_ff[2];
   assign rsp_hit_leaf = o_leaf_ff;
   assign rsp_start_outside = o_so_ff;
   assign rsp_all_solid = o_solid_ff;
   assign rsp_hit_updated = o_upd_ff;
endmodule

// ===== rtl/convex_brush_segment_clip_core.sv =====
// Convex brush segment clipper top level: registers, front end, queue, back end.
// Planes enter one per transaction; the front end takes each plane through the accept,
// one multiply-accumulate per axis, then the queue write, and holds req_full until then.
// The back end evaluates each plane and, for a plane that splits the segment, runs its
// one-bit-per-cycle restoring divider before the update; it skips the divider when the
// fraction saturates, and the update too for a plane that does not split it. A result
// appears on the last plane of each brush and waits in an output register while the next
// planes are taken in; the back end holds the following result until that register is popped.
module convex_brush_segment_clip_core import cbsc_pkg::*; #(
   parameter int COORD_WIDTH = 20,
   parameter int FRACTION_BITS = 16,
   parameter int LEAF_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_new_trace,
   input  logic signed [NORMAL_BITS-1:0] req_normal_x,
   input  logic signed [NORMAL_BITS-1:0] req_normal_y,
   input  logic signed [NORMAL_BITS-1:0] req_normal_z,
   input  logic signed [COORD_WIDTH-1:0] req_plane_dist,
   input  logic [LEAF_BITS-1:0]         req_leaf_index,
   input  logic                         req_last_side,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [FRACTION_BITS:0]       rsp_hit_fraction,
   output logic signed [NORMAL_BITS-1:0] rsp_hit_normal_x,
   output logic signed [NORMAL_BITS-1:0] rsp_hit_normal_y,
   output logic signed [NORMAL_BITS-1:0] rsp_hit_normal_z,
   output logic [LEAF_BITS-1:0]         rsp_hit_leaf,
   output logic                         rsp_start_outside,
   output logic                         rsp_all_solid,
   output logic                         rsp_hit_updated,
   input  logic                         csr_we,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [3*COORD_WIDTH-1:0]     csr_wdata
);
   localparam int SW = COORD_WIDTH + 21;
   localparam int QW = 2*SW + 3*NORMAL_BITS + LEAF_BITS + 2;

   logic [3*COORD_WIDTH-1:0] start_ff, end_ff, bmin_ff, bmax_ff;
   logic [KIND_BITS-1:0] kind_ff;
   logic [COORD_WIDTH-2:0] radius_ff;
   logic [EPS_BITS-1:0] eps_ff;
   queue_wr_type qw;
   logic q_full, q_empty, q_pop;
   logic [QW-1:0] q_wdata, q_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff <= '0;
         bmin_ff <= '0;
         bmax_ff <= '0;
         kind_ff <= '0;
         radius_ff <= '0;
         eps_ff <= EPS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TRACE_START: start_ff <= csr_wdata;
            CSR_TRACE_END: end_ff <= csr_wdata;
            CSR_BOX_MIN: bmin_ff <= csr_wdata;
            CSR_BOX_MAX: bmax_ff <= csr_wdata;
            CSR_OBJECT_KIND: kind_ff <= csr_wdata[KIND_BITS-1:0];
            CSR_SPHERE_RADIUS: radius_ff <= csr_wdata[COORD_WIDTH-2:0];
            CSR_CLIP_EPSILON: eps_ff <= csr_wdata[EPS_BITS-1:0];
            default: ;
         endcase
      end
   end

   cbsc_front #(.CW(COORD_WIDTH), .LB(LEAF_BITS), .SW(SW)) u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_new_trace(req_new_trace),
      .req_normal_x(req_normal_x), .req_normal_y(req_normal_y),
      .req_normal_z(req_normal_z), .req_plane_dist(req_plane_dist),
      .req_leaf_index(req_leaf_index), .req_last_side(req_last_side),
      .trace_start(start_ff), .trace_end(end_ff), .box_min(bmin_ff),
      .box_max(bmax_ff), .object_kind(kind_ff), .sphere_radius(radius_ff),
      .qw(qw), .q_full(q_full), .q_data(q_wdata)
   );

   cbsc_queue #(.WIDTH(QW)) u_queue (
      .clock(clock), .reset(reset), .qw(qw), .full(q_full), .wdata(q_wdata),
      .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
   );

   cbsc_back #(.CW(COORD_WIDTH), .FB(FRACTION_BITS), .LB(LEAF_BITS), .SW(SW)) u_back (
      .clock(clock), .reset(reset),
      .q_empty(q_empty), .q_pop(q_pop), .q_data(q_rdata), .clip_epsilon(eps_ff),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_hit_fraction(rsp_hit_fraction),
      .rsp_hit_normal_x(rsp_hit_normal_x), .rsp_hit_normal_y(rsp_hit_normal_y),
      .rsp_hit_normal_z(rsp_hit_normal_z), .rsp_hit_leaf(rsp_hit_leaf),
      .rsp_start_outside(rsp_start_outside), .rsp_all_solid(rsp_all_solid),
      .rsp_hit_updated(rsp_hit_updated)
   );
endmodule

// ===== rtl/cbsc_checker.sv =====
// Port-level checks for the convex brush segment clipper, bound to the top level.
module cbsc_checker #(
   parameter int FRACTION_BITS = 16
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_empty,
   input logic                     rsp_pop,
   input logic [FRACTION_BITS:0]   rsp_hit_fraction,
   input logic                     rsp_start_outside,
   input logic                     rsp_all_solid,
   input logic                     rsp_hit_updated
);
   localparam logic [FRACTION_BITS:0] ONE_U = (FRACTION_BITS+1)'(1) << FRACTION_BITS;

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_hit_fraction)))
      else $error("waiting result changed or vanished");
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_hit_fraction <= ONE_U))
      else $error("hit fraction above one");
   a_update_hit: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_hit_updated) |-> (rsp_hit_fraction != ONE_U))
      else $error("updated hit reports no hit");
   a_solid_inside: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_all_solid) |-> !rsp_start_outside)
      else $error("all solid while start outside");
endmodule

bind convex_brush_segment_clip_core cbsc_checker #(.FRACTION_BITS(FRACTION_BITS)) u_checker (
   .clock(clock), .reset(reset), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
   .rsp_hit_fraction(rsp_hit_fraction), .rsp_start_outside(rsp_start_outside),
   .rsp_all_solid(rsp_all_solid), .rsp_hit_updated(rsp_hit_updated)
);
